// ===== design/pcpd_pkg.sv =====
// ----------------------------------------------------------------------------
// pcpd_pkg
// Shared types and constants of the patch column post decoder.
// ----------------------------------------------------------------------------
package pcpd_pkg;

  localparam int SCREEN_WIDTH_PIXELS  = 320;
  localparam int SCREEN_HEIGHT_PIXELS = 200;

  // width of the signed screen position sums
  localparam int PosW = 19;

  localparam logic [7:0] END_MARK = 8'hff;

  typedef enum logic [2:0] {
    PH_TOP      = 3'd0,
    PH_LEN      = 3'd1,
    PH_PAD_LEAD = 3'd2,
    PH_TEXEL    = 3'd3,
    PH_PAD_TAIL = 3'd4,
    PH_DONE     = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PIXEL     = 2'd0,
    KIND_DONE      = 2'd1,
    KIND_OFFSCREEN = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [8:0] pixel_x;
    logic [7:0] pixel_y;
    logic [7:0] color;
  } result_t;

endpackage

// ===== design/patch_column_post_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// patch_column_post_decoder_unit
// Turns the post bytes of sprite-patch columns into screen pixel writes.
// ----------------------------------------------------------------------------
// Input channel: one post-stream byte per beat, with the column index, patch
// origin and header offsets alongside; column_start_i marks a column's first
// byte. Output channel: at most one result per input beat (pixel write,
// column finished or off-screen pixel); pad, length and non-end top bytes
// give none. Throughput is one byte per cycle while in_stall_o is low: the
// phase machine and the position adds sit between the parser state and a
// result register. The result register is backed by a skid register, so a
// stalled receiver holds up the input only once both are full; in_stall_o
// is the skid register's valid flag.
// Reset clears parser state (expecting a post top byte) and the valid flags
// of both result registers; the block takes a beat straight out of reset.
// ----------------------------------------------------------------------------
module patch_column_post_decoder_unit
  import pcpd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               column_start_i,
  input  logic        [9:0]  column_index_i,
  input  logic signed [11:0] origin_x_i,
  input  logic signed [11:0] origin_y_i,
  input  logic signed [15:0] offset_x_i,
  input  logic signed [15:0] offset_y_i,
  input  logic        [7:0]  data_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic        [1:0]  kind_o,
  output logic        [8:0]  pixel_x_o,
  output logic        [7:0]  pixel_y_o,
  output logic        [7:0]  color_o
);

  logic    in_beat, out_pop, push;
  logic    res_valid;
  result_t res;
  logic    main_v_q, skid_v_q;
  result_t main_q, skid_q;

  assign in_stall_o = skid_v_q;
  assign in_beat    = in_valid_i && !skid_v_q;
  assign out_pop    = main_v_q && !out_stall_i;
  assign push       = in_beat && res_valid;

  pcpd_parser u_parser (
    .clk_i,
    .rst_ni,
    .beat_i         (in_beat),
    .column_start_i,
    .column_index_i,
    .origin_x_i,
    .origin_y_i,
    .offset_x_i,
    .offset_y_i,
    .data_byte_i,
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_pop) skid_v_q <= 1'b0;
    end else if (push) begin
      if (main_v_q && !out_pop) skid_v_q <= 1'b1;
      else                      main_v_q <= 1'b1;
    end else if (out_pop) begin
      main_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_pop) main_q <= skid_q;
    end else if (push) begin
      if (main_v_q && !out_pop) skid_q <= res;
      else                      main_q <= res;
    end
  end

  assign out_valid_o = main_v_q;
  assign kind_o      = main_q.kind;
  assign pixel_x_o   = main_q.pixel_x;
  assign pixel_y_o   = main_q.pixel_y;
  assign color_o     = main_q.color;

  // skid entry only ever backs up a full result register
  a_skid_needs_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> main_v_q)
    else $error("skid register full while result register empty");

  // a parked result moves into the result register when the receiver takes one
  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && out_pop |=> main_v_q && !skid_v_q)
    else $error("skid result not forwarded");

  // a result-bearing beat shows up at the output next cycle when nothing waits
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !main_v_q |=> out_valid_o)
    else $error("result lost on an idle output");

  // off-screen and finish results carry no position or color
  a_blank_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != KIND_PIXEL) |->
      (pixel_x_o == '0) && (pixel_y_o == '0) && (color_o == '0))
    else $error("non-pixel result with payload");

endmodule

// ===== design/pcpd_parser.sv =====
// ----------------------------------------------------------------------------
// pcpd_parser
// Post phase machine and pixel position logic; one byte per beat.
// ----------------------------------------------------------------------------
module pcpd_parser
  import pcpd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               beat_i,
  input  logic               column_start_i,
  input  logic        [9:0]  column_index_i,
  input  logic signed [11:0] origin_x_i,
  input  logic signed [11:0] origin_y_i,
  input  logic signed [15:0] offset_x_i,
  input  logic signed [15:0] offset_y_i,
  input  logic        [7:0]  data_byte_i,
  output logic               res_valid_o,
  output result_t            res_o
);

  phase_e     phase_q, phase_d;
  logic [7:0] top_q, top_d;
  logic [7:0] left_q, left_d;
  logic [7:0] row_q, row_d;

  phase_e     cur_phase;
  logic [7:0] left_dec;
  logic signed [PosW-1:0] px, py;
  logic       on_screen;

  assign px = PosW'(origin_x_i) - PosW'(offset_x_i) + $signed({9'd0, column_index_i});
  assign py = PosW'(origin_y_i) - PosW'(offset_y_i)
            + $signed({11'd0, top_q}) + $signed({11'd0, row_q});

  assign on_screen = !px[PosW-1] && !py[PosW-1]
                  && ($unsigned(px) < PosW'(SCREEN_WIDTH_PIXELS))
                  && ($unsigned(py) < PosW'(SCREEN_HEIGHT_PIXELS));

  assign left_dec = left_q - 8'd1;

  always_comb begin
    cur_phase   = column_start_i ? PH_TOP : phase_q;
    phase_d     = cur_phase;
    top_d       = top_q;
    left_d      = left_q;
    row_d       = row_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: KIND_PIXEL, pixel_x: '0, pixel_y: '0, color: '0};
    case (cur_phase)
      PH_TOP: begin
        if (data_byte_i == END_MARK) begin
          phase_d     = PH_DONE;
          res_valid_o = 1'b1;
          res_o.kind  = KIND_DONE;
        end else begin
          top_d   = data_byte_i;
          phase_d = PH_LEN;
        end
      end
      PH_LEN: begin
        left_d  = data_byte_i;
        row_d   = '0;
        phase_d = PH_PAD_LEAD;
      end
      PH_PAD_LEAD: begin
        phase_d = (left_q == '0) ? PH_PAD_TAIL : PH_TEXEL;
      end
      PH_TEXEL: begin
        row_d       = row_q + 8'd1;
        left_d      = left_dec;
        if (left_dec == '0) phase_d = PH_PAD_TAIL;
        res_valid_o = 1'b1;
        if (on_screen) begin
          res_o.kind    = KIND_PIXEL;
          res_o.pixel_x = px[8:0];
          res_o.pixel_y = py[7:0];
          res_o.color   = data_byte_i;
        end else begin
          res_o.kind = KIND_OFFSCREEN;
        end
      end
      PH_PAD_TAIL: begin
        phase_d = PH_TOP;
      end
      default: begin
        // column ended (or a dead code): bytes are dropped
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TOP;
      top_q   <= '0;
      left_q  <= '0;
      row_q   <= '0;
    end else if (beat_i) begin
      phase_q <= phase_d;
      top_q   <= top_d;
      left_q  <= left_d;
      row_q   <= row_d;
    end
  end

endmodule
